/* design/line_segment_window_clipper_defines.svh */
// Assertion macros used by the checker file of the line segment window clipper.
// Depends on nothing; the including file supplies clock, reset and the signals.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSWC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lswc checker: same-cycle property violated");

// Consequent checked in the cycle after the antecedent.
`define LSWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lswc checker: next-cycle property violated");

`endif

/* design/lswc_pkg.sv */
// Package of the line segment window clipper: widths, codes, payload types and states.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lswc_pkg;

    // Coordinate and arithmetic widths.
    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int STEP_BITS  = $clog2(COORD_BITS);

    // Edge moves allowed before a segment is given up as rejected.
    localparam int MAX_PASSES = 16;
    localparam int PASS_BITS  = $clog2(MAX_PASSES + 1);

    // Region code bit positions.
    localparam int CODE_BITS   = 4;
    localparam int CODE_LEFT   = 0;
    localparam int CODE_RIGHT  = 1;
    localparam int CODE_BOTTOM = 2;
    localparam int CODE_TOP    = 3;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LEFT   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_BOTTOM = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_RIGHT  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_TOP    = CFG_INDEX_BITS'(3);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic [CODE_BITS-1:0]         t_code;

    // Window reset values.
    localparam t_coord WIN_LEFT_RESET   = t_coord'(0);
    localparam t_coord WIN_BOTTOM_RESET = t_coord'(0);
    localparam t_coord WIN_RIGHT_RESET  = t_coord'(639);
    localparam t_coord WIN_TOP_RESET    = t_coord'(479);

    typedef struct packed {
        t_coord left;
        t_coord bottom;
        t_coord right;
        t_coord top;
    } t_window;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg_in;

    typedef struct packed {
        logic   accepted;
        t_coord clipped_start_x;
        t_coord clipped_start_y;
        t_coord clipped_end_x;
        t_coord clipped_end_y;
    } t_clip_out;

    // Operands of one edge intersection: base + trunc(span * num / den).
    typedef struct packed {
        t_coord base;
        t_diff  span;
        t_diff  num;
        t_diff  den;
    } t_interp_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TEST,
        S_CALC,
        S_DRAIN
    } t_clip_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV,
        D_FIX
    } t_div_state;

endpackage

/* design/line_segment_window_clipper.sv */
// Top level of the line segment window clipper: window registers, pass sequencer,
// outcode logic and output register. Depends on lswc_pkg, lswc_outcode, lswc_interp.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one segment (t_seg_in) per transfer.
//   Output channel: o_out_valid / i_out_stall carry one result (t_clip_out) per segment.
//   Configuration: i_cfg_valid / o_cfg_ready write i_cfg_data to window register
//   i_cfg_index (0 left, 1 bottom, 2 right, 3 top); other indexes are ignored.
//   Write the window only while no segment is in flight.
// Timing:
//   Each clip pass is an outcode test, one multiply and a one-bit-per-cycle
//   restoring divide on the single shared intersection unit. A segment needs
//   0 to 4 passes for an ordinary window and up to 16 for an inverted one.
//   The segment is held and the input stalls for the whole clip.
// Reset and stall:
//   Reset loads the default 640 by 480 window and empties the block. A stalled
//   result waits in the output register; the sequencer then holds the finished
//   segment and keeps the input stalled until the result register frees up.
`timescale 1ns / 1ps

module line_segment_window_clipper import lswc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_seg_in                   i_seg,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_clip_out                 o_clip,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  t_coord                    i_cfg_data
);

    t_window              r_win;
    t_clip_state          r_state;
    t_clip_state          n_state;
    t_coord               r_x1;
    t_coord               r_y1;
    t_coord               r_x2;
    t_coord               r_y2;
    logic [PASS_BITS-1:0] r_pass;
    logic                 r_acc;
    logic                 r_move_end;
    logic                 r_vert;
    t_coord               r_edge;
    logic                 r_out_valid;
    t_clip_out            r_out;

    t_code       code1;
    t_code       code2;
    t_code       code_sel;
    logic        both_inside;
    logic        decided;
    logic        in_xfer;
    logic        out_free;
    logic        ip_start;
    logic        out_load;
    logic        sel_vert;
    t_coord      sel_edge;
    t_interp_req req;
    logic        ip_done;
    t_coord      ip_result;
    t_coord      new_x;
    t_coord      new_y;

    // Signed difference of two coordinates, one bit wider.
    function automatic t_diff diff(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_clip      = r_out;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Window register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= WIN_LEFT_RESET;
            r_win.bottom <= WIN_BOTTOM_RESET;
            r_win.right  <= WIN_RIGHT_RESET;
            r_win.top    <= WIN_TOP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LEFT:   r_win.left   <= i_cfg_data;
                CFG_WINDOW_BOTTOM: r_win.bottom <= i_cfg_data;
                CFG_WINDOW_RIGHT:  r_win.right  <= i_cfg_data;
                CFG_WINDOW_TOP:    r_win.top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Outcodes of the current endpoints.
    lswc_outcode u_code1 (
        .i_x    (r_x1),
        .i_y    (r_y1),
        .i_win  (r_win),
        .o_code (code1)
    );

    lswc_outcode u_code2 (
        .i_x    (r_x2),
        .i_y    (r_y2),
        .i_win  (r_win),
        .o_code (code2)
    );

    // Trivial accept, trivial reject or pass limit ends the clip.
    assign both_inside = (code1 == '0) && (code2 == '0);
    assign decided     = both_inside || ((code1 & code2) != '0)
                         || (r_pass == PASS_BITS'(MAX_PASSES));

    // Edge choice for the first outside endpoint: top, bottom, left, right.
    always_comb begin
        code_sel = (code1 != '0) ? code1 : code2;
        sel_vert = 1'b1;
        sel_edge = r_win.right;
        if (code_sel[CODE_TOP]) begin
            sel_vert = 1'b0;
            sel_edge = r_win.top;
        end else if (code_sel[CODE_BOTTOM]) begin
            sel_vert = 1'b0;
            sel_edge = r_win.bottom;
        end else if (code_sel[CODE_LEFT]) begin
            sel_edge = r_win.left;
        end
    end

    // Intersection operands from the current endpoints.
    always_comb begin
        if (sel_vert) begin
            req.base = r_y1;
            req.span = diff(r_y2, r_y1);
            req.num  = diff(sel_edge, r_x1);
            req.den  = diff(r_x2, r_x1);
        end else begin
            req.base = r_x1;
            req.span = diff(r_x2, r_x1);
            req.num  = diff(sel_edge, r_y1);
            req.den  = diff(r_y2, r_y1);
        end
    end

    lswc_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ip_start),
        .i_req    (req),
        .o_done   (ip_done),
        .o_result (ip_result)
    );

    // The moved point sits on the chosen edge; the other coordinate is computed.
    assign new_x = r_vert ? r_edge : ip_result;
    assign new_y = r_vert ? ip_result : r_edge;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer) begin
                n_state = S_TEST;
            end
            S_TEST:  n_state = decided ? S_DRAIN : S_CALC;
            S_CALC:  if (ip_done) begin
                n_state = S_TEST;
            end
            S_DRAIN: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = 1'b1;
        ip_start   = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_TEST:  ip_start   = !decided;
            S_CALC:  ;
            S_DRAIN: out_load   = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Segment working registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x1   <= i_seg.start_x;
            r_y1   <= i_seg.start_y;
            r_x2   <= i_seg.end_x;
            r_y2   <= i_seg.end_y;
            r_pass <= '0;
        end
        if (r_state == S_TEST) begin
            r_acc      <= both_inside;
            r_move_end <= (code1 == '0);
            r_vert     <= sel_vert;
            r_edge     <= sel_edge;
        end
        if (r_state == S_CALC && ip_done) begin
            r_pass <= r_pass + 1'b1;
            if (r_move_end) begin
                r_x2 <= new_x;
                r_y2 <= new_y;
            end else begin
                r_x1 <= new_x;
                r_y1 <= new_y;
            end
        end
    end

    // Result register; a rejected segment reports zero endpoints.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.accepted        <= r_acc;
            r_out.clipped_start_x <= r_acc ? r_x1 : '0;
            r_out.clipped_start_y <= r_acc ? r_y1 : '0;
            r_out.clipped_end_x   <= r_acc ? r_x2 : '0;
            r_out.clipped_end_y   <= r_acc ? r_y2 : '0;
        end
    end

endmodule

/* design/lswc_outcode.sv */
// Region outcode of one point against the clip window.
// Depends on lswc_pkg for the coordinate, window and code types.
`timescale 1ns / 1ps

module lswc_outcode import lswc_pkg::*; (
    input  t_coord  i_x,
    input  t_coord  i_y,
    input  t_window i_win,
    output t_code   o_code
);

    // Each bit is one signed compare against a window edge.
    always_comb begin
        o_code              = '0;
        o_code[CODE_TOP]    = i_y > i_win.top;
        o_code[CODE_BOTTOM] = i_y < i_win.bottom;
        o_code[CODE_LEFT]   = i_x < i_win.left;
        o_code[CODE_RIGHT]  = i_x > i_win.right;
    end

endmodule

/* design/lswc_interp.sv */
// Shared intersection unit: one multiply, then a restoring divide one bit per cycle.
// Depends on lswc_pkg for operand types, widths and the unit's state type.
`timescale 1ns / 1ps

module lswc_interp import lswc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_interp_req i_req,
    output logic        o_done,
    output t_coord      o_result
);

    t_div_state             r_state;
    t_div_state             n_state;
    t_coord                 r_base;
    logic                   r_neg;
    logic [COORD_BITS-1:0]  r_mag_span;
    logic [COORD_BITS-1:0]  r_mag_num;
    logic [COORD_BITS-1:0]  r_mag_den;
    logic [COORD_BITS-1:0]  r_rem;
    logic [COORD_BITS-1:0]  r_low;
    logic [STEP_BITS-1:0]   r_step;
    logic [PROD_BITS-1:0]   prod;
    logic [COORD_BITS:0]    trial;
    logic                   q_bit;
    logic                   last_step;

    // Magnitude of a difference; every difference here stays below 2^COORD_BITS.
    function automatic logic [COORD_BITS-1:0] magnitude(input t_diff v);
        t_diff neg_v;
        neg_v = -v;
        return v[DIFF_BITS-1] ? neg_v[COORD_BITS-1:0] : v[COORD_BITS-1:0];
    endfunction

    assign prod      = PROD_BITS'(r_mag_span) * PROD_BITS'(r_mag_num);
    assign trial     = {r_rem, r_low[COORD_BITS-1]} - {1'b0, r_mag_den};
    assign q_bit     = !trial[COORD_BITS];
    assign last_step = r_step == STEP_BITS'(COORD_BITS - 1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_start) begin
                n_state = D_MUL;
            end
            D_MUL:   n_state = D_DIV;
            D_DIV:   if (last_step) begin
                n_state = D_FIX;
            end
            D_FIX:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    // Outputs: the quotient is applied to the base with its sign; done is raised in D_FIX.
    always_comb begin
        o_done   = 1'b0;
        o_result = r_neg ? t_coord'(r_base - r_low) : t_coord'(r_base + r_low);
        unique case (r_state)
            D_FIX:   o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand capture, product split and quotient shifting.
    // The product's upper half is already below the divisor, so only the
    // lower COORD_BITS bits need a divide step each.
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_base     <= i_req.base;
            r_mag_span <= magnitude(i_req.span);
            r_mag_num  <= magnitude(i_req.num);
            r_mag_den  <= magnitude(i_req.den);
            r_neg      <= i_req.span[DIFF_BITS-1] ^ i_req.num[DIFF_BITS-1]
                          ^ i_req.den[DIFF_BITS-1];
        end
        if (r_state == D_MUL) begin
            r_rem  <= prod[PROD_BITS-1:COORD_BITS];
            r_low  <= prod[COORD_BITS-1:0];
            r_step <= '0;
        end
        if (r_state == D_DIV) begin
            r_rem  <= q_bit ? trial[COORD_BITS-1:0]
                            : {r_rem[COORD_BITS-2:0], r_low[COORD_BITS-1]};
            r_low  <= {r_low[COORD_BITS-2:0], q_bit};
            r_step <= r_step + 1'b1;
        end
    end

endmodule

/* design/lswc_checker.sv */
// Port-level checker of the line segment window clipper, bound to the top level.
// Depends on lswc_pkg and the macros of line_segment_window_clipper_defines.svh.
`timescale 1ns / 1ps
`include "line_segment_window_clipper_defines.svh"

module lswc_checker import lswc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_clip_out o_clip
);

    // A rejected result carries zero endpoints.
    `LSWC_ASSERT_SAME(a_reject_zero, i_clk, i_rst_n, o_out_valid && !o_clip.accepted, (o_clip.clipped_start_x == '0) && (o_clip.clipped_start_y == '0) && (o_clip.clipped_end_x == '0) && (o_clip.clipped_end_y == '0))

    // A segment transfer is followed by a closed input.
    `LSWC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A new result only appears after the input was closed.
    `LSWC_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    // A stalled result stays valid and unchanged.
    `LSWC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_clip))

endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_clip      (o_clip)
);

/* tb/sv/line_segment_window_clipper_test.sv */
// Self-checking testbench for the line segment window clipper: directed and random segments
// against many clip windows, every result checked against an in-bench clipping predictor.
// Depends on lswc_pkg and the line_segment_window_clipper top level.
`timescale 1ns / 1ps

module line_segment_window_clipper_test;
    import lswc_pkg::*;

    // Drain wait covers the longest clip of sixteen passes, plus a margin.
    localparam int     DRAIN_CYCLES = MAX_PASSES * (COORD_BITS + 3) + 16;
    localparam int     IDLE_PERCENT = 7;
    localparam int     REPORT_LIMIT = 10;
    localparam longint RUN_LIMIT_NS = 2_000_000;

    // Indexes outside the register file; writes to them must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_FIRST = CFG_WINDOW_TOP
                                                             + CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LAST  = '1;

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    t_seg_in                   seg_bus   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    t_clip_out                 clip_bus;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    t_coord                    cfg_data  = '0;

    // Window as the block should hold it, segments waiting to be sent, results due.
    t_window   win_model = '{WIN_LEFT_RESET, WIN_BOTTOM_RESET, WIN_RIGHT_RESET, WIN_TOP_RESET};
    t_seg_in   seg_pending[$];
    t_clip_out clip_expected[$];
    int        fail_count  = 0;
    bit        quiet_phase = 1'b0;

    line_segment_window_clipper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_seg       (seg_bus),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_clip      (clip_bus),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Random idle cycle for either side, switched off during the quiet phase.
    function automatic bit take_idle();
        return !quiet_phase && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Region code of a point against the current window.
    function automatic t_code region_code(longint x, longint y);
        t_code c;
        c = '0;
        c[CODE_TOP]    = y > win_model.top;
        c[CODE_BOTTOM] = y < win_model.bottom;
        c[CODE_LEFT]   = x < win_model.left;
        c[CODE_RIGHT]  = x > win_model.right;
        return c;
    endfunction

    // Crossing with an edge: base + span * num / den, quotient truncated toward zero.
    function automatic longint edge_cross(longint base, longint span, longint num, longint den);
        if (den == 0) begin
            return base;
        end
        return base + (span * num) / den;
    endfunction

    // Cohen-Sutherland clip of one segment against win_model.
    function automatic t_clip_out clip_segment(t_seg_in seg);
        longint    x1, y1, x2, y2, nx, ny;
        t_code     c1, c2, c;
        t_clip_out res;
        bit        accept;
        int        pass;
        x1 = seg.start_x;
        y1 = seg.start_y;
        x2 = seg.end_x;
        y2 = seg.end_y;
        c1 = region_code(x1, y1);
        c2 = region_code(x2, y2);
        accept = 1'b0;
        for (pass = 0; pass <= MAX_PASSES; pass++) begin
            if (c1 == '0 && c2 == '0) begin
                accept = 1'b1;
                break;
            end
            if ((c1 & c2) != '0) break;
            // A segment that never settles is given up as rejected.
            if (pass == MAX_PASSES) break;
            c = (c1 != '0) ? c1 : c2;
            if (c[CODE_TOP]) begin
                ny = win_model.top;
                nx = edge_cross(x1, x2 - x1, ny - y1, y2 - y1);
            end else if (c[CODE_BOTTOM]) begin
                ny = win_model.bottom;
                nx = edge_cross(x1, x2 - x1, ny - y1, y2 - y1);
            end else if (c[CODE_LEFT]) begin
                nx = win_model.left;
                ny = edge_cross(y1, y2 - y1, nx - x1, x2 - x1);
            end else begin
                nx = win_model.right;
                ny = edge_cross(y1, y2 - y1, nx - x1, x2 - x1);
            end
            if (c1 != '0) begin
                x1 = nx;
                y1 = ny;
                c1 = region_code(x1, y1);
            end else begin
                x2 = nx;
                y2 = ny;
                c2 = region_code(x2, y2);
            end
        end
        res = '0;
        if (accept) begin
            res.accepted        = 1'b1;
            res.clipped_start_x = t_coord'(x1);
            res.clipped_start_y = t_coord'(y1);
            res.clipped_end_x   = t_coord'(x2);
            res.clipped_end_y   = t_coord'(y2);
        end
        return res;
    endfunction

    // Segment driver: a transfer at this edge is predicted, then the next segment is offered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                clip_expected.push_back(clip_segment(seg_bus));
            end
            if (seg_pending.size() != 0 && !take_idle()) begin
                seg_bus  <= seg_pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: each transfer is compared with the oldest expected result.
    always @(posedge i_clk) begin : result_monitor
        t_clip_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (clip_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("ERROR: unexpected result %0d (%0d,%0d)-(%0d,%0d)",
                                 clip_bus.accepted, clip_bus.clipped_start_x,
                                 clip_bus.clipped_start_y, clip_bus.clipped_end_x,
                                 clip_bus.clipped_end_y);
                    end
                end else begin
                    want = clip_expected.pop_front();
                    if (want.accepted !== clip_bus.accepted
                        || want.clipped_start_x !== clip_bus.clipped_start_x
                        || want.clipped_start_y !== clip_bus.clipped_start_y
                        || want.clipped_end_x !== clip_bus.clipped_end_x
                        || want.clipped_end_y !== clip_bus.clipped_end_y) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display({"ERROR: clip mismatch: expected %0d (%0d,%0d)-(%0d,%0d)",
                                      ", got %0d (%0d,%0d)-(%0d,%0d)"},
                                     want.accepted, want.clipped_start_x,
                                     want.clipped_start_y, want.clipped_end_x,
                                     want.clipped_end_y, clip_bus.accepted,
                                     clip_bus.clipped_start_x, clip_bus.clipped_start_y,
                                     clip_bus.clipped_end_x, clip_bus.clipped_end_y);
                        end
                    end
                end
            end
            out_stall <= take_idle();
        end
    end

    // One register write; the model follows only the four window registers.
    task automatic write_window_reg(input logic [CFG_INDEX_BITS-1:0] index, input t_coord value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_WINDOW_LEFT:   win_model.left   = value;
            CFG_WINDOW_BOTTOM: win_model.bottom = value;
            CFG_WINDOW_RIGHT:  win_model.right  = value;
            CFG_WINDOW_TOP:    win_model.top    = value;
            default: ;
        endcase
    endtask

    task automatic set_window(input t_coord left, input t_coord bottom,
                              input t_coord right, input t_coord top);
        write_window_reg(CFG_WINDOW_LEFT, left);
        write_window_reg(CFG_WINDOW_BOTTOM, bottom);
        write_window_reg(CFG_WINDOW_RIGHT, right);
        write_window_reg(CFG_WINDOW_TOP, top);
    endtask

    // Sender holds off until every segment is sent and every result has come back.
    task automatic wait_drained();
        while (seg_pending.size() != 0 || in_valid || clip_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic queue_segment(input t_coord sx, input t_coord sy,
                                 input t_coord ex, input t_coord ey);
        seg_pending.push_back('{sx, sy, ex, ey});
    endtask

    // Coordinate around the span [a, b], reaching half the span plus 8 beyond either side.
    function automatic t_coord near_coord(t_coord a, t_coord b);
        longint lo, hi, margin, v;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        margin = (hi - lo) / 2 + 8;
        v = lo - margin + longint'($urandom_range(int'(hi - lo + 2 * margin)));
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return t_coord'(v);
    endfunction

    // Random segments: anywhere, around the window, or one end around it and one anywhere.
    task automatic queue_random(input int count);
        t_coord sx, sy, ex, ey;
        for (int n = 0; n < count; n++) begin
            sx = near_coord(win_model.left, win_model.right);
            sy = near_coord(win_model.bottom, win_model.top);
            ex = near_coord(win_model.left, win_model.right);
            ey = near_coord(win_model.bottom, win_model.top);
            case ($urandom_range(3))
                0: begin
                    sx = t_coord'($urandom);
                    sy = t_coord'($urandom);
                    ex = t_coord'($urandom);
                    ey = t_coord'($urandom);
                end
                3: begin
                    ex = t_coord'($urandom);
                    ey = t_coord'($urandom);
                end
                default: ;
            endcase
            queue_segment(sx, sy, ex, ey);
        end
    endtask

    // Random span, mostly narrow, sometimes anything up to the full range.
    task automatic pick_span(output t_coord lo, output t_coord hi, input bit flip);
        int unsigned w, off;
        t_coord      t;
        w   = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1000);
        off = $urandom_range(65535 - w);
        lo  = t_coord'(-32768 + longint'(off));
        hi  = t_coord'(-32768 + longint'(off) + longint'(w));
        if (flip) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
    endtask

    // One phase: a fresh window, random segments, then a full drain.
    task automatic random_phase(input int count, input bit flip_x, input bit flip_y);
        t_coord l, b, r, t;
        pick_span(l, r, flip_x);
        pick_span(b, t, flip_y);
        set_window(l, b, r, t);
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        int mode;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default 640 by 480 window straight out of reset.
        queue_segment(10, 10, 600, 400);             // inside
        queue_segment(0, 0, 639, 479);               // on the edges
        queue_segment(5, 5, 5, 5);                   // single point
        queue_segment(0, 0, 0, 0);
        queue_segment(-100, 5, -50, 300);            // both left
        queue_segment(-1, -1, -1, -1);               // left and bottom
        queue_segment(100, 100, 200, 1000);          // crosses top
        queue_segment(300, 200, 350, -700);          // crosses bottom
        queue_segment(-300, 200, 300, 250);          // crosses left
        queue_segment(300, 200, 900, 100);           // crosses right
        queue_segment(320, -50, 320, 600);           // vertical through both edges
        queue_segment(-100, 240, 800, 240);          // horizontal through both sides
        queue_segment(-100, -100, 800, 600);         // both ends clipped
        queue_segment(-100, 400, 100, 700);          // misses the corner
        queue_segment(-32768, -32768, 32767, 32767);
        queue_segment(32767, -32768, -32768, 32767);
        wait_drained();

        // Writes to unused indexes leave the window alone.
        write_window_reg(CFG_UNUSED_FIRST, 16'sd100);
        write_window_reg(CFG_UNUSED_LAST, -16'sd1);
        queue_segment(-10, 240, 700, 240);
        queue_segment(320, -5, 320, 500);
        wait_drained();

        // Full range window: everything is accepted unchanged.
        set_window(-32768, -32768, 32767, 32767);
        queue_segment(-32768, 32767, 32767, -32768);
        queue_segment(32767, 32767, 32767, 32767);
        queue_segment(-32768, -32768, -32768, -32768);
        queue_segment(-1, 0, 0, -1);
        queue_random(40);
        wait_drained();

        // Ordinary windows; one phase runs with no idling on either side.
        for (int phase = 0; phase < 6; phase++) begin
            quiet_phase = (phase == 3);
            random_phase(55, 1'b0, 1'b0);
        end
        quiet_phase = 1'b0;

        // Inverted windows: points may carry both codes of a pair.
        set_window(400, 0, 200, 479);
        queue_segment(300, 100, 300, 200);
        queue_segment(100, 100, 500, 200);
        queue_segment(-500, 600, 900, -300);
        wait_drained();
        for (int phase = 0; phase < 2; phase++) begin
            mode = $urandom_range(2);
            random_phase(50, mode != 1, mode != 0);
        end

        // Single point windows at opposite corners of the coordinate range.
        set_window(32767, -32768, 32767, -32768);
        queue_segment(-32768, 32767, 32767, -32768);
        queue_random(29);
        wait_drained();
        set_window(-32768, 32767, -32768, 32767);
        queue_segment(-32768, 32767, 32767, -32768);
        queue_random(29);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && clip_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
